FILE: rtl/core/csog_pkg.sv
`default_nettype none
package csog_pkg;

	localparam int COORD_BITS = 16;
	localparam int DATA_W     = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int IDX_W      = 6;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t COORD_MAX = ~COORD_MIN;

	typedef enum logic [2:0] {
		CLS_1,
		CLS_6,
		CLS_12,
		CLS_24Z,
		CLS_8,
		CLS_24AB,
		CLS_24BC,
		CLS_48
	} cls_t;

	// sorted triple a <= b <= c plus its orbit class
	typedef struct packed {
		coord_t a;
		coord_t b;
		coord_t c;
		cls_t   cls;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nempty;
	} qstat_t;

	// image component codes: zero, +-a, +-b, +-c
	typedef logic [2:0] code_t;
	localparam code_t ZR = 3'd0;
	localparam code_t PA = 3'd1;
	localparam code_t PB = 3'd2;
	localparam code_t PC = 3'd3;
	localparam code_t NC = 3'd5;
	localparam code_t NB = 3'd6;
	localparam code_t NA = 3'd7;

	typedef struct packed {
		code_t x;
		code_t y;
		code_t z;
	} row_t;

	localparam row_t TAB6 [6] = '{
		'{ZR,ZR,PC}, '{ZR,PC,ZR}, '{PC,ZR,ZR}, '{ZR,ZR,NC}, '{ZR,NC,ZR}, '{NC,ZR,ZR}};

	localparam row_t TAB12 [12] = '{
		'{ZR,PB,PB}, '{PB,ZR,PB}, '{PB,PB,ZR}, '{ZR,PB,NB}, '{PB,ZR,NB}, '{PB,NB,ZR},
		'{ZR,NB,PB}, '{NB,ZR,PB}, '{NB,PB,ZR}, '{ZR,NB,NB}, '{NB,ZR,NB}, '{NB,NB,ZR}};

	localparam row_t TAB24Z [24] = '{
		'{ZR,PB,PC}, '{PB,ZR,PC}, '{PB,PC,ZR}, '{ZR,PB,NC}, '{PB,ZR,NC}, '{PB,NC,ZR},
		'{ZR,NB,PC}, '{NB,ZR,PC}, '{NB,PC,ZR}, '{ZR,NB,NC}, '{NB,ZR,NC}, '{NB,NC,ZR},
		'{ZR,PC,PB}, '{PC,ZR,PB}, '{PC,PB,ZR}, '{ZR,PC,NB}, '{PC,ZR,NB}, '{PC,NB,ZR},
		'{ZR,NC,PB}, '{NC,ZR,PB}, '{NC,PB,ZR}, '{ZR,NC,NB}, '{NC,ZR,NB}, '{NC,NB,ZR}};

	localparam row_t TAB8 [8] = '{
		'{PA,PA,PA}, '{PA,PA,NA}, '{PA,NA,PA}, '{NA,PA,PA},
		'{PA,NA,NA}, '{NA,PA,NA}, '{NA,NA,PA}, '{NA,NA,NA}};

	localparam row_t TAB24AB [24] = '{
		'{PA,PA,PC}, '{PA,PC,PA}, '{PC,PA,PA}, '{PA,PA,NC}, '{PA,NC,PA}, '{NC,PA,PA},
		'{NA,PA,PC}, '{NA,PC,PA}, '{PC,NA,PA}, '{NA,PA,NC}, '{NA,NC,PA}, '{NC,NA,PA},
		'{PA,NA,PC}, '{PA,PC,NA}, '{PC,PA,NA}, '{PA,NA,NC}, '{PA,NC,NA}, '{NC,PA,NA},
		'{NA,NA,PC}, '{NA,PC,NA}, '{PC,NA,NA}, '{NA,NA,NC}, '{NA,NC,NA}, '{NC,NA,NA}};

	localparam row_t TAB24BC [24] = '{
		'{PA,PB,PB}, '{PB,PA,PB}, '{PB,PB,PA}, '{PA,PB,NB}, '{PB,PA,NB}, '{PB,NB,PA},
		'{PA,NB,PB}, '{NB,PA,PB}, '{NB,PB,PA}, '{PA,NB,NB}, '{NB,PA,NB}, '{NB,NB,PA},
		'{NA,PB,PB}, '{PB,NA,PB}, '{PB,PB,NA}, '{NA,PB,NB}, '{PB,NA,NB}, '{PB,NB,NA},
		'{NA,NB,PB}, '{NB,NA,PB}, '{NB,PB,NA}, '{NA,NB,NB}, '{NB,NA,NB}, '{NB,NB,NA}};

	localparam row_t TAB48 [48] = '{
		'{PA,PB,PC}, '{PB,PA,PC}, '{PB,PC,PA}, '{PA,PB,NC}, '{PB,PA,NC}, '{PB,NC,PA},
		'{PA,NB,PC}, '{NB,PA,PC}, '{NB,PC,PA}, '{PA,NB,NC}, '{NB,PA,NC}, '{NB,NC,PA},
		'{PA,PC,PB}, '{PC,PA,PB}, '{PC,PB,PA}, '{PA,PC,NB}, '{PC,PA,NB}, '{PC,NB,PA},
		'{PA,NC,PB}, '{NC,PA,PB}, '{NC,PB,PA}, '{PA,NC,NB}, '{NC,PA,NB}, '{NC,NB,PA},
		'{NA,PB,PC}, '{PB,NA,PC}, '{PB,PC,NA}, '{NA,PB,NC}, '{PB,NA,NC}, '{PB,NC,NA},
		'{NA,NB,PC}, '{NB,NA,PC}, '{NB,PC,NA}, '{NA,NB,NC}, '{NB,NA,NC}, '{NB,NC,NA},
		'{NA,PC,PB}, '{PC,NA,PB}, '{PC,PB,NA}, '{NA,PC,NB}, '{PC,NA,NB}, '{PC,NB,NA},
		'{NA,NC,PB}, '{NC,NA,PB}, '{NC,PB,NA}, '{NA,NC,NB}, '{NC,NA,NB}, '{NC,NB,NA}};

	function automatic row_t img_row(input cls_t cls, input logic [IDX_W-1:0] idx);
		row_t r;
		r = '{ZR, ZR, ZR};
		unique case (cls)
			CLS_1:    r = '{ZR, ZR, ZR};
			CLS_6:    r = TAB6[idx[2:0]];
			CLS_12:   r = TAB12[idx[3:0]];
			CLS_24Z:  r = TAB24Z[idx[4:0]];
			CLS_8:    r = TAB8[idx[2:0]];
			CLS_24AB: r = TAB24AB[idx[4:0]];
			CLS_24BC: r = TAB24BC[idx[4:0]];
			CLS_48:   r = TAB48[idx];
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] last_idx(input cls_t cls);
		logic [IDX_W-1:0] n;
		n = '0;
		unique case (cls)
			CLS_1:    n = IDX_W'(0);
			CLS_6:    n = IDX_W'(5);
			CLS_12:   n = IDX_W'(11);
			CLS_24Z:  n = IDX_W'(23);
			CLS_8:    n = IDX_W'(7);
			CLS_24AB: n = IDX_W'(23);
			CLS_24BC: n = IDX_W'(23);
			CLS_48:   n = IDX_W'(47);
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/csog_front.sv
`default_nettype none
module csog_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire csog_pkg::coord_t                     in_v0,
	input  wire csog_pkg::coord_t                     in_v1,
	input  wire csog_pkg::coord_t                     in_v2,
	input  wire csog_pkg::qstat_t                     qstat,
	output logic                                      push,
	output csog_pkg::entry_t                          push_entry
);
	import csog_pkg::*;

	logic   valid_s1;
	coord_t lo_s1, hi_s1, v2_s1;
	coord_t m1, a, b, c;
	cls_t   cls;

	assign push     = valid_s1 && !qstat.full;
	assign in_ready = !valid_s1 || !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// first compare-and-swap sits ahead of the stage register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lo_s1 <= (in_v0 > in_v1) ? in_v1 : in_v0;
			hi_s1 <= (in_v0 > in_v1) ? in_v0 : in_v1;
			v2_s1 <= in_v2;
		end
	end

	always_comb begin
		m1 = (hi_s1 > v2_s1) ? v2_s1 : hi_s1;
		c  = (hi_s1 > v2_s1) ? hi_s1 : v2_s1;
		a  = (lo_s1 > m1) ? m1 : lo_s1;
		b  = (lo_s1 > m1) ? lo_s1 : m1;
	end

	always_comb begin
		priority if (a == '0) begin
			if (b == '0) begin
				cls = (c == '0) ? CLS_1 : CLS_6;
			end else begin
				cls = (b == c) ? CLS_12 : CLS_24Z;
			end
		end else if (a == b && b == c) begin
			cls = CLS_8;
		end else if (a == b) begin
			cls = CLS_24AB;
		end else if (b == c) begin
			cls = CLS_24BC;
		end else begin
			cls = CLS_48;
		end
	end

	assign push_entry = '{a: a, b: b, c: c, cls: cls};

endmodule
`default_nettype wire

FILE: rtl/core/csog_queue.sv
`default_nettype none
module csog_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire csog_pkg::entry_t  push_entry,
	input  wire logic              pop,
	output csog_pkg::entry_t       pop_entry,
	output csog_pkg::qstat_t       qstat
);
	import csog_pkg::*;

	entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign qstat.full   = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign qstat.nempty = (cnt_q != '0);
	assign pop_entry    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/csog_back.sv
`default_nettype none
module csog_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire csog_pkg::qstat_t  qstat,
	input  wire csog_pkg::entry_t  pop_entry,
	output logic                   pop,
	output logic                   busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output csog_pkg::coord_t       out_x,
	output csog_pkg::coord_t       out_y,
	output csog_pkg::coord_t       out_z,
	output logic                   out_last
);
	import csog_pkg::*;

	logic               busy_q, ovalid_q, olast_q;
	logic [IDX_W-1:0]   idx_q;
	cls_t               cls_q;
	coord_t             a_q, b_q, c_q, na_q, nb_q, nc_q;
	coord_t             ox_q, oy_q, oz_q;
	logic               load, last;
	row_t               row;

	function automatic coord_t neg_sat(input coord_t v);
		return (v == COORD_MIN) ? COORD_MAX : -v;
	endfunction

	function automatic coord_t pick(input code_t code, input coord_t a, input coord_t b,
			input coord_t c, input coord_t na, input coord_t nb, input coord_t nc);
		coord_t r;
		r = '0;
		unique case (code)
			PA:      r = a;
			PB:      r = b;
			PC:      r = c;
			NA:      r = na;
			NB:      r = nb;
			NC:      r = nc;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign load = busy_q && (!ovalid_q || out_ready);
	assign last = (idx_q == last_idx(cls_q));
	assign pop  = qstat.nempty && (!busy_q || (load && last));
	assign row  = img_row(cls_q, idx_q);

	assign busy      = busy_q;
	assign out_valid = ovalid_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_z     = oz_q;
	assign out_last  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// negated copies are formed once per item, off the table walk
	always_ff @(posedge clk) begin
		if (pop) begin
			a_q   <= pop_entry.a;
			b_q   <= pop_entry.b;
			c_q   <= pop_entry.c;
			na_q  <= neg_sat(pop_entry.a);
			nb_q  <= neg_sat(pop_entry.b);
			nc_q  <= neg_sat(pop_entry.c);
			cls_q <= pop_entry.cls;
		end
		if (load) begin
			ox_q    <= pick(row.x, a_q, b_q, c_q, na_q, nb_q, nc_q);
			oy_q    <= pick(row.y, a_q, b_q, c_q, na_q, nb_q, nc_q);
			oz_q    <= pick(row.z, a_q, b_q, c_q, na_q, nb_q, nc_q);
			olast_q <= last;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/cubic_symmetry_orbit_generator_core.sv
// Cubic symmetry orbit generator.
// Input stream s_axis: one beat carries a lattice vector (three signed components).
// Output stream m_axis: the signed permutations of that vector in fixed table order,
// one beat each, tlast on the final image of the orbit. An input yields 1, 6, 8, 12,
// 24 or 48 output beats depending on zeros and repeats among the sorted components.
// Path: sort stage, queue write, queue read into the generator, output register.
// Throughput: the generator emits one image per cycle unless a low m_axis_tready holds
// the output register, so an input occupies it for 1 to 48 images (48 when the sorted
// components are all distinct and the smallest is nonzero); that table walk sets the
// sustained rate. The front sorts and classifies one beat per cycle while the queue
// has room and parks results in a 4-entry queue, so inputs keep being taken while the
// generator works.
// Back-pressure: a low m_axis_tready holds the output register; the generator and then
// the queue fill, and s_axis_tready drops once the queue and the sort stage are full.
// Reset: arst_n clears all valid state; no beat is lost or duplicated across stalls.
`default_nettype none
module cubic_symmetry_orbit_generator_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// first_value, second_value, third_value (lowest bits first)
	input  wire logic [csog_pkg::DATA_W-1:0]   s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// out_x, out_y, out_z (lowest bits first)
	output logic [csog_pkg::DATA_W-1:0]        m_axis_tdata,
	output logic                               m_axis_tlast
);
	import csog_pkg::*;

	qstat_t qstat;
	entry_t push_entry, pop_entry;
	logic   push, pop, busy;
	coord_t out_x, out_y, out_z;

	csog_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_v0      (coord_t'(s_axis_tdata[COORD_BITS-1:0])),
		.in_v1      (coord_t'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
		.in_v2      (coord_t'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	csog_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	csog_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.busy      (busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = DATA_W'({out_z, out_y, out_x});

`ifndef SYNTHESIS
	// a full queue means the generator already holds an item
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> busy)
		else $error("queue full while generator idle");

	// no bubble inside one orbit
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside an orbit");

	// only the all-zero orbit has a zero image, and it is a single beat
	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_x == '0 && out_y == '0 && out_z == '0 |-> m_axis_tlast)
		else $error("zero image without tlast");
`endif

endmodule
`default_nettype wire

FILE: sim/orbit_checker.sv
module orbit_checker
	import csog_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	// first_value, second_value, third_value (lowest bits first)
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	// out_x, out_y, out_z (lowest bits first)
	input  wire logic [DATA_W-1:0] m_tdata,
	input  wire logic              m_tlast,
	output int                     fail_count,
	output int                     pending,
	output int                     vec_count,
	output int                     image_count,
	output logic [7:0]             cls_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} orbit_img_t;

	// sign flips of the all-equal orbit, bit 2 = x, bit 0 = z
	localparam logic [2:0] NEG_MASK8 [8] = '{
		3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b101, 3'b110, 3'b111};

	orbit_img_t orbit_q [$];

	initial begin
		fail_count  = 0;
		pending     = 0;
		vec_count   = 0;
		image_count = 0;
		cls_seen    = '0;
	end

	function automatic coord_t neg_sat(input coord_t v);
		return (v == COORD_MIN) ? COORD_MAX : -v;
	endfunction

	function automatic orbit_img_t orbit_image(input cls_t cls, input coord_t a,
			input coord_t b, input coord_t c, input int k, input int n);
		orbit_img_t img;
		coord_t     na, p, q, r;
		int         g, j;
		logic [2:0] m;
		na = neg_sat(a);
		g = k / 6;
		j = k % 6;
		img.last = (k == n - 1);
		case (cls)
			CLS_1: begin
				{img.x, img.y, img.z} = '0;
			end
			CLS_6: begin
				// +-c walks from z to x, positive pass first
				p = (j >= 3) ? neg_sat(c) : c;
				img.x = (j % 3 == 2) ? p : coord_t'(0);
				img.y = (j % 3 == 1) ? p : coord_t'(0);
				img.z = (j % 3 == 0) ? p : coord_t'(0);
			end
			CLS_8: begin
				m = NEG_MASK8[k[2:0]];
				img.x = m[2] ? na : a;
				img.y = m[1] ? na : a;
				img.z = m[0] ? na : a;
			end
			CLS_24AB: begin
				p = g[0] ? na : a;
				q = g[1] ? na : a;
				r = (j >= 3) ? neg_sat(c) : c;
				case (j % 3)
					0:       {img.x, img.y, img.z} = {p, q, r};
					1:       {img.x, img.y, img.z} = {p, r, q};
					default: {img.x, img.y, img.z} = {r, p, q};
				endcase
			end
			default: begin
				// full signed permutation walk; the smaller orbits are subsets of its groups
				if (cls == CLS_24BC && g >= 2)
					g = g + 2;
				p = (g >= 4) ? na : a;
				case (g % 4)
					0: begin
						q = b;
						r = c;
					end
					1: begin
						q = neg_sat(b);
						r = c;
					end
					2: begin
						q = c;
						r = b;
					end
					default: begin
						q = neg_sat(c);
						r = b;
					end
				endcase
				if (j >= 3)
					r = neg_sat(r);
				case (j % 3)
					0:       {img.x, img.y, img.z} = {p, q, r};
					1:       {img.x, img.y, img.z} = {q, p, r};
					default: {img.x, img.y, img.z} = {q, r, p};
				endcase
			end
		endcase
		return img;
	endfunction

	task automatic predict_orbit(input coord_t v0, input coord_t v1, input coord_t v2);
		coord_t a, b, c, t;
		cls_t   cls;
		int     n;
		a = v0;
		b = v1;
		c = v2;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (b > c) begin
			t = b; b = c; c = t;
		end
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (a == 0) begin
			if (b == 0)
				cls = (c == 0) ? CLS_1 : CLS_6;
			else if (b == c)
				cls = CLS_12;
			else
				cls = CLS_24Z;
		end else if (a == b && b == c)
			cls = CLS_8;
		else if (a == b)
			cls = CLS_24AB;
		else if (b == c)
			cls = CLS_24BC;
		else
			cls = CLS_48;
		case (cls)
			CLS_1:   n = 1;
			CLS_6:   n = 6;
			CLS_8:   n = 8;
			CLS_12:  n = 12;
			CLS_48:  n = 48;
			default: n = 24;
		endcase
		cls_seen[cls] = 1'b1;
		for (int k = 0; k < n; k++)
			orbit_q.insert(orbit_q.size(), orbit_image(cls, a, b, c, k, n));
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns  MISMATCH  %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		orbit_img_t want;
		coord_t     gx, gy, gz;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_orbit(s_tdata[0 +: COORD_BITS], s_tdata[COORD_BITS +: COORD_BITS],
					s_tdata[2*COORD_BITS +: COORD_BITS]);
				vec_count++;
			end
			if (m_tvalid && m_tready) begin
				gx = m_tdata[0 +: COORD_BITS];
				gy = m_tdata[COORD_BITS +: COORD_BITS];
				gz = m_tdata[2*COORD_BITS +: COORD_BITS];
				image_count++;
				if (orbit_q.size() == 0)
					report_mismatch($sformatf("image (%0d,%0d,%0d) last=%0b with none expected",
						gx, gy, gz, m_tlast));
				else begin
					want = orbit_q.pop_front();
					if (gx !== want.x)
						report_mismatch($sformatf("image %0d x: got %0d want %0d",
							image_count, gx, want.x));
					if (gy !== want.y)
						report_mismatch($sformatf("image %0d y: got %0d want %0d",
							image_count, gy, want.y));
					if (gz !== want.z)
						report_mismatch($sformatf("image %0d z: got %0d want %0d",
							image_count, gz, want.z));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("image %0d tlast: got %b want %b",
							image_count, m_tlast, want.last));
				end
			end
			pending = orbit_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
module testbench
	import csog_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 88;
	localparam int HOLD_CYCLES = 300;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	int         fail_count;
	int         pending;
	int         vec_count;
	int         image_count;
	logic [7:0] cls_seen;

	bit rx_hold   = 1'b0;
	bit rx_steady = 1'b0;

	cubic_symmetry_orbit_generator_core dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tlast
	);

	orbit_checker orbit_chk (
		.clk,
		.arst_n,
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tlast     (m_axis_tlast),
		.fail_count,
		.pending,
		.vec_count,
		.image_count,
		.cls_seen
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int rand_stall();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(16, 40);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return coord_t'(int'($urandom_range(0, 16)) - 8);
			4, 5, 6, 7: return coord_t'($urandom);
			8:          return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
			default:    return $urandom_range(0, 1) ? coord_t'(COORD_MIN + 1) : coord_t'(-1);
		endcase
	endfunction

	// plain: leave components independent (mostly full 48-image orbits)
	task automatic rand_vec(output coord_t x, output coord_t y, output coord_t z,
			input bit plain);
		coord_t t;
		x = rand_coord();
		y = rand_coord();
		z = rand_coord();
		if (!plain) begin
			case ($urandom_range(0, 7))
				0: y = x;
				1: begin
					y = x;
					z = x;
				end
				2: x = '0;
				3: begin
					x = '0;
					z = y;
				end
				4: begin
					x = '0;
					y = '0;
				end
				5: {x, y, z} = '0;
				default: ;
			endcase
		end
		case ($urandom_range(0, 2))
			1: begin
				t = x; x = y; y = z; z = t;
			end
			2: begin
				t = z; z = y; y = x; x = t;
			end
			default: ;
		endcase
	endtask

	task automatic send_vec(input coord_t x, input coord_t y, input coord_t z, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'({z, y, x});
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// output side: random stalls, a long hold on request, none in steady stretches
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (!rx_steady && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (rand_stall()) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		#10ms;
		$display("Timed out with %0d images outstanding", pending);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		coord_t x, y, z;
		bit     burst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at least one per orbit class, then range extremes and saturating negation
		send_vec(0, 0, 0, rand_gap());
		send_vec(0, 0, 5, rand_gap());
		send_vec(0, -7, 0, rand_gap());
		send_vec(0, 3, 3, rand_gap());
		send_vec(4, 0, 9, rand_gap());
		send_vec(5, 5, 5, rand_gap());
		send_vec(-6, -6, -6, rand_gap());
		send_vec(2, 2, 7, rand_gap());
		send_vec(7, 2, 2, rand_gap());
		send_vec(1, 2, 3, rand_gap());
		send_vec(-3, 2, -1, rand_gap());
		send_vec(32767, -32767, 0, rand_gap());
		send_vec(-32768, 1, 2, rand_gap());
		send_vec(-32768, -32768, -32768, rand_gap());
		send_vec(32767, 32767, 32767, rand_gap());
		send_vec(-32768, 0, 0, rand_gap());
		send_vec(0, 0, -32768, rand_gap());
		send_vec(0, -32768, -32768, rand_gap());
		send_vec(-32768, 32767, 0, rand_gap());
		send_vec(0, 0, 32767, rand_gap());
		send_vec(-1, -1, -1, rand_gap());
		send_vec(16'h5555, 16'haaaa, 16'h7fff, rand_gap());
		send_vec(16'haaaa, 16'h5555, 16'h8001, rand_gap());

		for (int i = 0; i < N_RANDOM; i++) begin
			// back-to-back beats while the output side is held off
			burst = (i >= 30 && i < 40);
			if (i == 30)
				rx_hold = 1'b1;
			if (i == 60) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			rx_steady = (i >= 70 && i < 86);
			rand_vec(x, y, z, burst);
			send_vec(x, y, z, (burst || rx_steady) ? 0 : rand_gap());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);

		$display("Sent %0d lattice vectors, checked %0d orbit images, %0d mismatches",
			vec_count, image_count, fail_count);
		$display("Orbit classes reached (one bit per class, class 0 rightmost): %b", cls_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/csog_pkg.sv
rtl/core/csog_front.sv
rtl/core/csog_queue.sv
rtl/core/csog_back.sv
rtl/core/cubic_symmetry_orbit_generator_core.sv
sim/orbit_checker.sv
sim/testbench.sv
